>>> hw/rtl/deadline_timer_queue_top_assert.svh
// assertion macros for the deadline timer queue
`ifndef DEADLINE_TIMER_QUEUE_TOP_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_TOP_ASSERT_SVH

// condition must never hold out of reset
`define DTQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define DTQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/dtq_pkg.sv
// shared types and constants of the deadline timer queue
package dtq_pkg;
  localparam int Slots = 16;
  localparam int SW = $clog2(Slots);
  localparam int PW = SW + 1;
  localparam logic [PW-1:0] NIL = PW'(Slots);
  localparam int QDEPTH = 2;

  localparam logic [2:0] FUNC_TICK   = 3'd0;
  localparam logic [2:0] FUNC_ALLOC  = 3'd1;
  localparam logic [2:0] FUNC_REARM  = 3'd2;
  localparam logic [2:0] FUNC_CANCEL = 3'd3;
  localparam logic [2:0] FUNC_FREE   = 3'd4;

  localparam logic [2:0] KIND_EXPIRY    = 3'd0;
  localparam logic [2:0] KIND_TICK_DONE = 3'd1;
  localparam logic [2:0] KIND_ARMED     = 3'd2;
  localparam logic [2:0] KIND_NO_FREE   = 3'd3;
  localparam logic [2:0] KIND_CANCELLED = 3'd4;
  localparam logic [2:0] KIND_NOT_ACT   = 3'd5;
  localparam logic [2:0] KIND_FREED     = 3'd6;

  localparam logic [9:0]  MS_LAST   = 10'd999;
  localparam logic [30:0] SEC_LAST  = 31'h7ffffffe;
  localparam logic [31:0] WRAP_LAST = 32'd3999999999;

  typedef enum logic [2:0] {
    OP_TICK, OP_ALLOC, OP_REARM, OP_CANCEL, OP_FREE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [31:0] tag;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } qctl_t;
endpackage

>>> hw/rtl/dtq_front.sv
// command decode and queue in front of the execution engine
module dtq_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     in_func,
  input  logic [3:0]     in_slot,
  input  logic [31:0]    in_delay,
  input  logic [31:0]    in_tag,
  input  logic           pop,
  output logic           q_valid,
  output dtq_pkg::cmd_t  q_cmd
);
  dtq_pkg::cmd_t q_mem_r [dtq_pkg::QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       known;
  dtq_pkg::op_t op;
  logic       push, do_pop;

  always_comb begin
    known = 1'b1;
    op = dtq_pkg::OP_TICK;
    case (in_func)
      dtq_pkg::FUNC_TICK:   op = dtq_pkg::OP_TICK;
      dtq_pkg::FUNC_ALLOC:  op = dtq_pkg::OP_ALLOC;
      dtq_pkg::FUNC_REARM:  op = dtq_pkg::OP_REARM;
      dtq_pkg::FUNC_CANCEL: op = dtq_pkg::OP_CANCEL;
      dtq_pkg::FUNC_FREE:   op = dtq_pkg::OP_FREE;
      default:              known = 1'b0;
    endcase
  end

  assign busy    = (cnt_r == 2'(dtq_pkg::QDEPTH));
  assign push    = start && !busy && known;
  assign q_valid = (cnt_r != 2'd0);
  assign do_pop  = pop && q_valid;
  assign q_cmd   = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{op: op, slot: in_slot, delay: in_delay, tag: in_tag};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
  end
endmodule

>>> hw/rtl/dtq_back.sv
// execution engine: sorted timer list, runtime counter and results
module dtq_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  dtq_pkg::cmd_t     q_cmd,
  output logic              pop,
  output logic              out_strobe,
  output logic [2:0]        out_kind,
  output logic [3:0]        out_slot_out,
  output logic [31:0]       out_tag_out,
  output logic [9:0]        out_millis,
  output logic [30:0]       out_seconds,
  output logic [31:0]       out_refreshes,
  output logic              out_last
);
  localparam int SW = dtq_pkg::SW;
  localparam int PW = dtq_pkg::PW;

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_UNLINK, S_ULWALK, S_FIN, S_ARM, S_ARWALK
  } state_t;

  state_t state_r;
  dtq_pkg::op_t op_r;
  logic [SW-1:0] s_r;
  logic [PW-1:0] p_r, head_r, sn_r;
  logic [31:0] d_r, tick_r, wrap_r;
  logic [9:0]  ms_r;
  logic [30:0] sec_r;
  logic [dtq_pkg::Slots-1:0] alloc_r, active_r;
  logic [31:0]   dl_mem_r   [dtq_pkg::Slots];
  logic [31:0]   tag_mem_r  [dtq_pkg::Slots];
  logic [PW-1:0] succ_mem_r [dtq_pkg::Slots];

  // one read address per store, picked by state
  logic [SW-1:0] dl_addr, tag_addr, succ_addr;
  logic [31:0]   dl_rd, tag_rd;
  logic [PW-1:0] succ_rd;
  logic [SW-1:0] cs;
  logic          in_rng, free_found;
  logic [SW-1:0] free_idx;

  assign cs     = SW'(q_cmd.slot);
  assign in_rng = (32'(q_cmd.slot) < 32'(dtq_pkg::Slots));

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = dtq_pkg::Slots - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    dl_addr   = head_r[SW-1:0];
    tag_addr  = s_r;
    succ_addr = p_r[SW-1:0];
    case (state_r)
      S_EXP: begin
        tag_addr  = head_r[SW-1:0];
        succ_addr = head_r[SW-1:0];
      end
      S_UNLINK: succ_addr = s_r;
      S_ARWALK: dl_addr = succ_rd[SW-1:0];
      default: ;
    endcase
  end

  assign dl_rd   = dl_mem_r[dl_addr];
  assign tag_rd  = tag_mem_r[tag_addr];
  assign succ_rd = succ_mem_r[succ_addr];
  assign pop     = (state_r == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      op_r       <= dtq_pkg::OP_TICK;
      head_r     <= dtq_pkg::NIL;
      alloc_r    <= '0;
      active_r   <= '0;
      tick_r     <= '0;
      ms_r       <= '0;
      sec_r      <= '0;
      wrap_r     <= '0;
      out_strobe <= 1'b0;
      out_last   <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      out_last   <= 1'b0;
      out_millis    <= ms_r;
      out_seconds   <= sec_r;
      out_refreshes <= wrap_r;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            op_r <= q_cmd.op;
            s_r  <= (q_cmd.op == dtq_pkg::OP_ALLOC) ? free_idx : cs;
            d_r  <= q_cmd.delay + tick_r;
            case (q_cmd.op)
              dtq_pkg::OP_TICK: begin
                tick_r <= tick_r + 32'd1;
                if (ms_r == dtq_pkg::MS_LAST) begin
                  ms_r <= '0;
                  if (sec_r == dtq_pkg::SEC_LAST) begin
                    sec_r  <= '0;
                    wrap_r <= (wrap_r == dtq_pkg::WRAP_LAST) ? '0 : wrap_r + 32'd1;
                  end else begin
                    sec_r <= sec_r + 31'd1;
                  end
                end else begin
                  ms_r <= ms_r + 10'd1;
                end
                state_r <= S_EXP;
              end
              dtq_pkg::OP_ALLOC: begin
                if (!free_found) begin
                  out_strobe   <= 1'b1;
                  out_last     <= 1'b1;
                  out_kind     <= dtq_pkg::KIND_NO_FREE;
                  out_slot_out <= '0;
                  out_tag_out  <= '0;
                end else begin
                  alloc_r[free_idx]   <= 1'b1;
                  tag_mem_r[free_idx] <= q_cmd.tag;
                  state_r <= S_ARM;
                end
              end
              dtq_pkg::OP_REARM: begin
                if (!in_rng || !alloc_r[cs]) begin
                  out_strobe   <= 1'b1;
                  out_last     <= 1'b1;
                  out_kind     <= dtq_pkg::KIND_NOT_ACT;
                  out_slot_out <= q_cmd.slot;
                  out_tag_out  <= '0;
                end else begin
                  state_r <= active_r[cs] ? S_UNLINK : S_ARM;
                end
              end
              dtq_pkg::OP_CANCEL: begin
                if (!in_rng || !active_r[cs]) begin
                  out_strobe   <= 1'b1;
                  out_last     <= 1'b1;
                  out_kind     <= dtq_pkg::KIND_NOT_ACT;
                  out_slot_out <= q_cmd.slot;
                  out_tag_out  <= '0;
                end else begin
                  state_r <= S_UNLINK;
                end
              end
              dtq_pkg::OP_FREE: begin
                if (!in_rng) begin
                  out_strobe   <= 1'b1;
                  out_last     <= 1'b1;
                  out_kind     <= dtq_pkg::KIND_NOT_ACT;
                  out_slot_out <= q_cmd.slot;
                  out_tag_out  <= '0;
                end else begin
                  state_r <= active_r[cs] ? S_UNLINK : S_FIN;
                end
              end
              default: ;
            endcase
          end
        end
        S_EXP: begin
          out_strobe   <= 1'b1;
          if (head_r == dtq_pkg::NIL || dl_rd > tick_r) begin
            out_last     <= 1'b1;
            out_kind     <= dtq_pkg::KIND_TICK_DONE;
            out_slot_out <= '0;
            out_tag_out  <= '0;
            state_r      <= S_IDLE;
          end else begin
            out_kind     <= dtq_pkg::KIND_EXPIRY;
            out_slot_out <= 4'(head_r);
            out_tag_out  <= tag_rd;
            active_r[head_r[SW-1:0]] <= 1'b0;
            head_r <= succ_rd;
          end
        end
        S_UNLINK: begin
          sn_r <= succ_rd;
          if (head_r == PW'(s_r)) begin
            head_r  <= succ_rd;
            state_r <= S_FIN;
          end else begin
            p_r     <= head_r;
            state_r <= S_ULWALK;
          end
        end
        S_ULWALK: begin
          if (p_r == dtq_pkg::NIL) begin
            state_r <= S_FIN;
          end else if (succ_rd == PW'(s_r)) begin
            succ_mem_r[p_r[SW-1:0]] <= sn_r;
            state_r <= S_FIN;
          end else begin
            p_r <= succ_rd;
          end
        end
        S_FIN: begin
          if (op_r == dtq_pkg::OP_REARM) begin
            state_r <= S_ARM;
          end else begin
            out_strobe   <= 1'b1;
            out_last     <= 1'b1;
            out_slot_out <= 4'(s_r);
            active_r[s_r] <= 1'b0;
            if (op_r == dtq_pkg::OP_CANCEL) begin
              out_kind    <= dtq_pkg::KIND_CANCELLED;
              out_tag_out <= tag_rd;
            end else begin
              out_kind    <= dtq_pkg::KIND_FREED;
              out_tag_out <= '0;
              alloc_r[s_r] <= 1'b0;
            end
            state_r <= S_IDLE;
          end
        end
        S_ARM: begin
          dl_mem_r[s_r] <= d_r;
          active_r[s_r] <= 1'b1;
          if (head_r == dtq_pkg::NIL || d_r <= dl_rd) begin
            succ_mem_r[s_r] <= head_r;
            head_r       <= PW'(s_r);
            out_strobe   <= 1'b1;
            out_last     <= 1'b1;
            out_kind     <= dtq_pkg::KIND_ARMED;
            out_slot_out <= 4'(s_r);
            out_tag_out  <= tag_rd;
            state_r      <= S_IDLE;
          end else begin
            p_r     <= head_r;
            state_r <= S_ARWALK;
          end
        end
        S_ARWALK: begin
          if (succ_rd == dtq_pkg::NIL || d_r <= dl_rd) begin
            succ_mem_r[p_r[SW-1:0]] <= PW'(s_r);
            succ_mem_r[s_r]         <= succ_rd;
            out_strobe   <= 1'b1;
            out_last     <= 1'b1;
            out_kind     <= dtq_pkg::KIND_ARMED;
            out_slot_out <= 4'(s_r);
            out_tag_out  <= tag_rd;
            state_r      <= S_IDLE;
          end else begin
            p_r <= succ_rd;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/deadline_timer_queue_top.sv
// top level of the deadline timer queue
// A pool of 16 timer slots kept as one list sorted by absolute deadline. A command
// transaction is taken when start is high and busy is low; a two-entry command queue
// sits in front of the execution engine, so busy rises only when that queue is full.
// Each result appears for exactly one cycle with out_strobe high and must be taken
// then: there is no way to stall the result side. out_last marks the final result
// of a command. The single list engine walks one link per cycle: a tick walks past
// each expired timer; allocate and re-arm walk the list for the sorted insert;
// cancel and free walk it to unlink the slot, free of an unarmed slot skips that
// walk; re-arm of an armed slot pays both walks; a rejected command is answered
// from the idle state with no walk. Unknown funcs are dropped.
module deadline_timer_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic [31:0] in_delay,
  input  logic [31:0] in_tag,
  output logic        out_strobe,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_slot_out,
  output logic [31:0] out_tag_out,
  output logic [9:0]  out_millis,
  output logic [30:0] out_seconds,
  output logic [31:0] out_refreshes,
  output logic        out_last
);
  `include "deadline_timer_queue_top_assert.svh"

  // handshake between the command queue and the engine
  dtq_pkg::qctl_t qctl;
  dtq_pkg::cmd_t  q_cmd;

  dtq_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_slot(in_slot), .in_delay(in_delay), .in_tag(in_tag),
    .pop(qctl.pop), .q_valid(qctl.valid), .q_cmd(q_cmd)
  );

  dtq_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(qctl.valid), .q_cmd(q_cmd), .pop(qctl.pop),
    .out_strobe(out_strobe), .out_kind(out_kind), .out_slot_out(out_slot_out),
    .out_tag_out(out_tag_out), .out_millis(out_millis), .out_seconds(out_seconds),
    .out_refreshes(out_refreshes), .out_last(out_last)
  );

  // a command is only taken by the engine when one is queued
  `DTQ_ASSERT_IMPLY(a_pop_valid, qctl.pop, qctl.valid, "pop from empty queue")
  // last only marks a real result
  `DTQ_ASSERT_IMPLY(a_last_strobe, out_last, out_strobe, "last without strobe")
  // result kinds and millis stay in range
  `DTQ_ASSERT_NEVER(a_kind_rng, out_strobe && (out_kind == 3'd7 || out_millis > 10'd999),
    "result field out of range")
endmodule

>>> tb/tb_deadline_timer_queue_top.sv
// self-checking testbench of the deadline timer queue top level
module tb_deadline_timer_queue_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIL_IDX = dtq_pkg::Slots;

  // one expected result of the block
  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic [9:0]  millis;
    logic [30:0] seconds;
    logic [31:0] refreshes;
    logic        last;
  } timer_result_t;

  // one row of the directed table; check_row selects the typed-in result
  typedef struct {
    logic [2:0]  func;
    logic [3:0]  slot;
    logic [31:0] delay;
    logic [31:0] tag;
    bit          check_row;
    logic [2:0]  want_kind;
    logic [3:0]  want_slot;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_func;
  logic [3:0]  in_slot;
  logic [31:0] in_delay;
  logic [31:0] in_tag;
  logic        out_strobe;
  logic [2:0]  out_kind;
  logic [3:0]  out_slot_out;
  logic [31:0] out_tag_out;
  logic [9:0]  out_millis;
  logic [30:0] out_seconds;
  logic [31:0] out_refreshes;
  logic        out_last;

  // predictor copy of the timer state
  logic [31:0] deadline_q [dtq_pkg::Slots];
  logic [31:0] tag_q [dtq_pkg::Slots];
  bit          alloc_q [dtq_pkg::Slots];
  bit          armed_q [dtq_pkg::Slots];
  int          next_q [dtq_pkg::Slots];
  int          head_q;
  logic [31:0] ticks_q;
  logic [9:0]  ms_q;
  logic [30:0] sec_q;
  logic [31:0] wraps_q;

  timer_result_t pending_results[$];
  int mismatches;
  // queue index of the first result of the latest predicted command
  int first_new;

  deadline_timer_queue_top i_dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  // queue a predicted result stamped with the current runtime counter
  function automatic void push_result(logic [2:0] kind, int s, logic [31:0] tag);
    timer_result_t r;
    r.kind = kind;
    r.slot = s[3:0];
    r.tag = tag;
    r.millis = ms_q;
    r.seconds = sec_q;
    r.refreshes = wraps_q;
    r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void unlink_timer(int s);
    int p;
    if (head_q == s) begin
      head_q = next_q[s];
      return;
    end
    p = head_q;
    for (int n = 0; n < dtq_pkg::Slots && p < dtq_pkg::Slots; n++) begin
      if (next_q[p] == s) begin
        next_q[p] = next_q[s];
        return;
      end
      p = next_q[p];
    end
  endfunction

  // sorted insert, new timer ahead of equal deadlines
  function automatic void arm_timer(int s, logic [31:0] delay);
    logic [31:0] d;
    int p;
    int c;
    d = delay + ticks_q;
    deadline_q[s] = d;
    armed_q[s] = 1'b1;
    if (head_q >= dtq_pkg::Slots || d <= deadline_q[head_q]) begin
      next_q[s] = head_q;
      head_q = s;
      return;
    end
    p = head_q;
    for (int n = 0; n < dtq_pkg::Slots; n++) begin
      c = next_q[p];
      if (c >= dtq_pkg::Slots || d <= deadline_q[c]) begin
        next_q[p] = s;
        next_q[s] = c;
        return;
      end
      p = c;
    end
    next_q[s] = NIL_IDX;
  endfunction

  function automatic void advance_runtime();
    ms_q++;
    if (ms_q == 10'd1000) begin
      ms_q = '0;
      sec_q++;
      if (sec_q == 31'h7fffffff) begin
        sec_q = '0;
        wraps_q++;
        if (wraps_q == 32'd4000000000) begin
          ms_q = '0;
          sec_q = '0;
          wraps_q = '0;
        end
      end
    end
  endfunction

  // work out the results of one accepted command transaction
  function automatic void predict_timer_cmd(logic [2:0] func, logic [3:0] slot,
                                            logic [31:0] delay, logic [31:0] tag);
    int s;
    int base_idx;
    base_idx = pending_results.size();
    first_new = base_idx;
    case (func)
      dtq_pkg::FUNC_TICK: begin
        ticks_q++;
        advance_runtime();
        for (int n = 0; n < dtq_pkg::Slots; n++) begin
          s = head_q;
          if (s >= dtq_pkg::Slots || deadline_q[s] > ticks_q) break;
          head_q = next_q[s];
          armed_q[s] = 1'b0;
          push_result(dtq_pkg::KIND_EXPIRY, s, tag_q[s]);
        end
        push_result(dtq_pkg::KIND_TICK_DONE, 0, '0);
      end
      dtq_pkg::FUNC_ALLOC: begin
        s = 0;
        while (s < dtq_pkg::Slots && alloc_q[s]) s++;
        if (s >= dtq_pkg::Slots) begin
          push_result(dtq_pkg::KIND_NO_FREE, 0, '0);
        end else begin
          alloc_q[s] = 1'b1;
          tag_q[s] = tag;
          arm_timer(s, delay);
          push_result(dtq_pkg::KIND_ARMED, s, tag);
        end
      end
      dtq_pkg::FUNC_REARM: begin
        if (!alloc_q[slot]) begin
          push_result(dtq_pkg::KIND_NOT_ACT, slot, '0);
        end else begin
          if (armed_q[slot]) unlink_timer(slot);
          arm_timer(slot, delay);
          push_result(dtq_pkg::KIND_ARMED, slot, tag_q[slot]);
        end
      end
      dtq_pkg::FUNC_CANCEL: begin
        if (!armed_q[slot]) begin
          push_result(dtq_pkg::KIND_NOT_ACT, slot, '0);
        end else begin
          unlink_timer(slot);
          armed_q[slot] = 1'b0;
          push_result(dtq_pkg::KIND_CANCELLED, slot, tag_q[slot]);
        end
      end
      dtq_pkg::FUNC_FREE: begin
        if (armed_q[slot]) unlink_timer(slot);
        armed_q[slot] = 1'b0;
        alloc_q[slot] = 1'b0;
        push_result(dtq_pkg::KIND_FREED, slot, '0);
      end
      default: ;
    endcase
    if (pending_results.size() > base_idx)
      pending_results[pending_results.size() - 1].last = 1'b1;
  endfunction

  // result checker: the block cannot be stalled, so every strobe is compared
  always @(posedge clk) begin
    timer_result_t w;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d slot=%0d", out_kind, out_slot_out);
      end else begin
        w = pending_results.pop_front();
        if (out_kind !== w.kind || out_slot_out !== w.slot || out_tag_out !== w.tag ||
            out_millis !== w.millis || out_seconds !== w.seconds ||
            out_refreshes !== w.refreshes || out_last !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp k%0d s%0d t%h ms%0d sec%0d r%0d l%0d",
                     w.kind, w.slot, w.tag, w.millis, w.seconds, w.refreshes, w.last,
                     " got k%0d s%0d t%h ms%0d sec%0d r%0d l%0d",
                     out_kind, out_slot_out, out_tag_out, out_millis, out_seconds,
                     out_refreshes, out_last);
        end
      end
    end
  end

  // hold start low for a random gap, mostly short with a few long ones
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // present one command transaction and wait until it is taken
  task automatic send_cmd(logic [2:0] func, logic [3:0] slot,
                          logic [31:0] delay, logic [31:0] tag);
    start <= 1'b1;
    in_func <= func;
    in_slot <= slot;
    in_delay <= delay;
    in_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer_cmd(func, slot, delay, tag);
  endtask

  // random command, mostly well-formed with short delays so timers fire
  task automatic send_random_cmd();
    logic [2:0]  f;
    logic [3:0]  s;
    logic [31:0] d;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) f = dtq_pkg::FUNC_TICK;
    else if (pick < 62) f = dtq_pkg::FUNC_ALLOC;
    else if (pick < 76) f = dtq_pkg::FUNC_REARM;
    else if (pick < 86) f = dtq_pkg::FUNC_CANCEL;
    else if (pick < 96) f = dtq_pkg::FUNC_FREE;
    else f = 3'($urandom_range(5, 7));
    s = 4'($urandom_range(0, 15));
    d = ($urandom_range(0, 19) == 0) ? $urandom() : 32'($urandom_range(0, 12));
    send_cmd(f, s, d, $urandom());
  endtask

  // wait for the block to drain all expected results
  task automatic drain_results();
    while (pending_results.size() != 0) begin
      start <= 1'b0;
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  initial begin
    dir_row_t rows[$];
    mismatches = 0;
    first_new = 0;
    start = 1'b0;
    in_func = '0;
    in_slot = '0;
    in_delay = '0;
    in_tag = '0;
    rst_n = 1'b0;
    for (int i = 0; i < dtq_pkg::Slots; i++) begin
      alloc_q[i] = 1'b0;
      armed_q[i] = 1'b0;
      next_q[i] = NIL_IDX;
      deadline_q[i] = '0;
      tag_q[i] = '0;
    end
    head_q = NIL_IDX;
    ticks_q = '0;
    ms_q = '0;
    sec_q = '0;
    wraps_q = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty tick, errors, extremes, equal deadlines, full pool
    rows.push_back('{dtq_pkg::FUNC_TICK, 4'd0, 32'd0, 32'd0, 1,
                     dtq_pkg::KIND_TICK_DONE, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_CANCEL, 4'd3, 32'd0, 32'd0, 1,
                     dtq_pkg::KIND_NOT_ACT, 4'd3});
    rows.push_back('{dtq_pkg::FUNC_REARM, 4'd15, 32'd5, 32'd0, 1,
                     dtq_pkg::KIND_NOT_ACT, 4'd15});
    rows.push_back('{dtq_pkg::FUNC_FREE, 4'd9, 32'd0, 32'd0, 1,
                     dtq_pkg::KIND_FREED, 4'd9});
    rows.push_back('{dtq_pkg::FUNC_ALLOC, 4'd0, 32'hffffffff, 32'hffffffff, 1,
                     dtq_pkg::KIND_ARMED, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_ALLOC, 4'd0, 32'd2, 32'h0000_0001, 1,
                     dtq_pkg::KIND_ARMED, 4'd1});
    rows.push_back('{dtq_pkg::FUNC_ALLOC, 4'd0, 32'd2, 32'h8000_0000, 1,
                     dtq_pkg::KIND_ARMED, 4'd2});
    rows.push_back('{dtq_pkg::FUNC_ALLOC, 4'd0, 32'd0, 32'h5a5a_a5a5, 0, 3'd0, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_TICK, 4'd0, 32'd0, 32'd0, 0, 3'd0, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_TICK, 4'd0, 32'd0, 32'd0, 0, 3'd0, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_REARM, 4'd2, 32'd1, 32'd0, 0, 3'd0, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_REARM, 4'd0, 32'd3, 32'd0, 0, 3'd0, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_CANCEL, 4'd0, 32'd0, 32'd0, 0, 3'd0, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_FREE, 4'd2, 32'd0, 32'd0, 0, 3'd0, 4'd0});
    rows.push_back('{3'd7, 4'd0, 32'd0, 32'd0, 0, 3'd0, 4'd0});
    rows.push_back('{3'd5, 4'd15, 32'hffffffff, 32'hffffffff, 0, 3'd0, 4'd0});
    for (int i = 0; i < 14; i++)
      rows.push_back('{dtq_pkg::FUNC_ALLOC, 4'd0, 32'd4, 32'($urandom()), 0, 3'd0, 4'd0});
    rows.push_back('{dtq_pkg::FUNC_ALLOC, 4'd0, 32'd1, 32'd7, 1,
                     dtq_pkg::KIND_NO_FREE, 4'd0});
    for (int i = 0; i < 5; i++)
      rows.push_back('{dtq_pkg::FUNC_TICK, 4'd0, 32'd0, 32'd0, 0, 3'd0, 4'd0});

    foreach (rows[i]) begin
      send_cmd(rows[i].func, rows[i].slot, rows[i].delay, rows[i].tag);
      // typed-in rows must agree with the predictor
      if (rows[i].check_row &&
          (pending_results[first_new].kind !== rows[i].want_kind ||
           pending_results[first_new].slot !== rows[i].want_slot)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: exp kind %0d slot %0d, predicted kind %0d slot %0d",
                   i, rows[i].want_kind, rows[i].want_slot,
                   pending_results[first_new].kind, pending_results[first_new].slot);
      end
      if ($urandom_range(0, 2) == 0) idle_gap();
    end
    drain_results();
    // release the full pool before the random part
    for (int i = 0; i < dtq_pkg::Slots; i++)
      send_cmd(dtq_pkg::FUNC_FREE, 4'(i), 32'd0, 32'd0);

    for (int i = 0; i < 420; i++) begin
      send_random_cmd();
      if ($urandom_range(0, 1) == 0) idle_gap();
    end
    start <= 1'b0;
    drain_results();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
